// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] XOR_SEED    = 8'hFF;
    localparam logic [BYTE_W-1:0] SOF_RESET   = 8'h01;
    localparam logic [BYTE_W-1:0] MAXLEN_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] LEN_MIN     = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_MAX    = 8'd1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } sfd_phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADSUM = 2'd2,
        KIND_BADLEN = 2'd3
    } sfd_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOF_BYTE = 1'd0,
        CFG_MAX_LEN  = 1'd1
    } sfd_cfg_idx_t;

    typedef struct packed {
        sfd_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              frame_type;
        logic [BYTE_W-1:0] position;
    } sfd_result_t;

    typedef struct packed {
        logic        vld;
        sfd_result_t res;
    } sfd_push_t;

endpackage

// ===== hdl/sfd_parse.sv =====
module sfd_parse
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output sfd_push_t            push
);

    logic [BYTE_W-1:0] sof_reg;
    logic [BYTE_W-1:0] max_len_reg;

    sfd_phase_t        phase_reg, phase_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic              type_reg, type_next;
    logic [BYTE_W-1:0] cnt_reg, cnt_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;

    logic [BYTE_W-1:0] cnt_inc;
    logic [BYTE_W-1:0] csum_xor;
    logic [BYTE_W-1:0] plen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_reg     <= SOF_RESET;
            max_len_reg <= MAXLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (sfd_cfg_idx_t'(cfg_index))
                CFG_SOF_BYTE: sof_reg     <= cfg_data;
                CFG_MAX_LEN:  max_len_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            type_reg  <= 1'b0;
            cnt_reg   <= '0;
            xor_reg   <= XOR_SEED;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
        end
    end

    assign cnt_inc  = cnt_reg + 8'd1;
    assign csum_xor = xor_reg ^ rx_byte;
    assign plen     = (len_reg >= LEN_MIN) ? (len_reg - LEN_MIN) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        push       = '0;
        case (phase_reg)
            PH_LEN:
            begin
                if (rx_byte < LEN_MIN || rx_byte > max_len_reg)
                begin
                    phase_next    = PH_HUNT;
                    xor_next      = XOR_SEED;
                    push.vld      = accept;
                    push.res.kind = KIND_BADLEN;
                end
                else
                begin
                    len_next   = rx_byte;
                    xor_next   = XOR_SEED ^ rx_byte;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (rx_byte > TYPE_MAX)
                begin
                    phase_next = PH_HUNT;
                    xor_next   = XOR_SEED;
                end
                else
                begin
                    type_next  = rx_byte[0];
                    xor_next   = xor_reg ^ rx_byte;
                    cnt_next   = '0;
                    phase_next = (len_reg == LEN_MIN) ? PH_CSUM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                push.vld            = accept;
                push.res.kind       = KIND_DATA;
                push.res.data       = rx_byte;
                push.res.frame_type = type_reg;
                push.res.position   = cnt_reg;
                xor_next            = xor_reg ^ rx_byte;
                cnt_next            = cnt_inc;
                if ({1'b0, cnt_inc} + 9'd2 >= {1'b0, len_reg})
                    phase_next = PH_CSUM;
            end
            PH_CSUM:
            begin
                push.vld            = accept;
                push.res.kind       = (csum_xor == '0) ? KIND_GOOD : KIND_BADSUM;
                push.res.frame_type = type_reg;
                push.res.position   = plen;
                phase_next          = PH_HUNT;
                xor_next            = XOR_SEED;
            end
            default:
            begin
                phase_next = (rx_byte == sof_reg) ? PH_LEN : PH_HUNT;
                xor_next   = XOR_SEED;
            end
        endcase
    end

`ifndef SYNTH
    a_badlen_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (push.vld && push.res.kind == KIND_BADLEN) |=> phase_reg == PH_HUNT)
        else $error("length error did not return to hunt");

    a_data_room: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> ({1'b0, cnt_reg} + 9'd2 < {1'b0, len_reg}))
        else $error("payload count ran past frame length");

    a_seed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT || phase_reg == PH_LEN) |-> xor_reg == XOR_SEED)
        else $error("checksum not seeded outside a frame");
`endif

endmodule

// ===== hdl/sfd_out_buf.sv =====
module sfd_out_buf
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sfd_push_t   push,
    output logic        ready,
    output logic        out_vld,
    output sfd_result_t out_res,
    input  logic        out_rdy
);

    logic        out_vld_reg;
    logic        skid_vld_reg;
    sfd_result_t out_res_reg;
    sfd_result_t skid_res_reg;
    logic        pop;

    assign pop     = out_vld_reg && out_rdy;
    assign ready   = !skid_vld_reg;
    assign out_vld = out_vld_reg;
    assign out_res = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
                skid_vld_reg <= 1'b0;
        end
        else if (push.vld)
        begin
            if (!out_vld_reg || pop)
                out_vld_reg <= 1'b1;
            else
                skid_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
                out_res_reg <= skid_res_reg;
        end
        else if (push.vld)
        begin
            if (!out_vld_reg || pop)
                out_res_reg <= push.res;
            else
                skid_res_reg <= push.res;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry without head entry");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> !push.vld)
        else $error("result pushed into full buffer");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && pop) |=> (out_vld_reg && !skid_vld_reg))
        else $error("skid entry lost on drain");
`endif

endmodule

// ===== hdl/serial_frame_deframer.sv =====
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    rx_byte
// out      output     out_valid/out_ready  kind, data, frame_type, position
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; each result is registered in the output buffer.
// Frame state updates in the same cycle the byte is taken; results go to a
// two-entry output buffer (head plus skid).
// in_ready drops only while the skid entry is occupied.
// Reset restores sof_byte 0x01, max_len 0xFF and the hunt state.
module serial_frame_deframer
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [BYTE_W-1:0]    data,
    output logic                 frame_type,
    output logic [BYTE_W-1:0]    position,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic        accept;
    sfd_push_t   push;
    sfd_result_t res;

    assign accept = in_valid && in_ready;

    sfd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    sfd_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .ready   (in_ready),
        .out_vld (out_valid),
        .out_res (res),
        .out_rdy (out_ready)
    );

    assign kind       = res.kind;
    assign data       = res.data;
    assign frame_type = res.frame_type;
    assign position   = res.position;

endmodule

// ===== bench/sfd_checker.sv =====
module sfd_checker
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [BYTE_W-1:0]    data,
    input  logic                 frame_type,
    input  logic [BYTE_W-1:0]    position,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BYTE_W-1:0] sof_q;
    logic [BYTE_W-1:0] max_len_q;

    sfd_phase_t        ph;
    logic [BYTE_W-1:0] flen;
    logic              ftype;
    logic [BYTE_W-1:0] nbytes;
    logic [BYTE_W-1:0] csum;

    sfd_result_t       expected_results[$];

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        sfd_result_t r;
        r = '0;
        case (ph)
            PH_LEN:
            begin
                if (b < LEN_MIN || b > max_len_q)
                begin
                    ph   = PH_HUNT;
                    csum = XOR_SEED;
                    r.kind = KIND_BADLEN;
                    expected_results.push_back(r);
                end
                else
                begin
                    flen = b;
                    csum = XOR_SEED ^ b;
                    ph   = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (b > TYPE_MAX)
                begin
                    ph   = PH_HUNT;
                    csum = XOR_SEED;
                end
                else
                begin
                    ftype  = b[0];
                    csum   = csum ^ b;
                    nbytes = '0;
                    if (flen == LEN_MIN)
                        ph = PH_CSUM;
                    else
                        ph = PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.kind       = KIND_DATA;
                r.data       = b;
                r.frame_type = ftype;
                r.position   = nbytes;
                expected_results.push_back(r);
                csum   = csum ^ b;
                nbytes = nbytes + 8'd1;
                if ({1'b0, nbytes} + 9'd2 >= {1'b0, flen})
                    ph = PH_CSUM;
            end
            PH_CSUM:
            begin
                csum = csum ^ b;
                if (csum == '0)
                    r.kind = KIND_GOOD;
                else
                    r.kind = KIND_BADSUM;
                r.frame_type = ftype;
                r.position   = (flen >= LEN_MIN) ? flen - LEN_MIN : '0;
                expected_results.push_back(r);
                ph   = PH_HUNT;
                csum = XOR_SEED;
            end
            default:
            begin
                if (b == sof_q)
                    ph = PH_LEN;
                else
                    ph = PH_HUNT;
                csum = XOR_SEED;
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sfd_result_t e;
        if (!rst_n)
        begin
            sof_q     = SOF_RESET;
            max_len_q = MAXLEN_RESET;
            ph        = PH_HUNT;
            flen      = '0;
            ftype     = 1'b0;
            nbytes    = '0;
            csum      = XOR_SEED;
            expected_results.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SOF_BYTE: sof_q = cfg_data;
                    CFG_MAX_LEN:  max_len_q = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none got kind %0d data %0d",
                             $time, kind, data);
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("kind", BYTE_W'(e.kind), BYTE_W'(kind));
                    check_field("data", e.data, data);
                    check_field("frame_type", BYTE_W'(e.frame_type), BYTE_W'(frame_type));
                    check_field("position", e.position, position);
                end
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/tb_serial_frame_deframer.sv =====
module tb_serial_frame_deframer;
    import sfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    data;
    logic                 frame_type;
    logic [BYTE_W-1:0]    position;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    int chk_errors;
    int chk_pending;

    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;
    int n_items;

    logic [BYTE_W-1:0] cur_sof;
    logic [BYTE_W-1:0] cur_max;

    logic [BYTE_W-1:0] phase_sof [4] = '{8'h7E, 8'h00, 8'hFF, 8'hA5};
    logic [BYTE_W-1:0] phase_max [4] = '{8'd20, 8'd2, 8'd0, 8'd255};

    serial_frame_deframer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data       (data),
        .frame_type (frame_type),
        .position   (position),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    sfd_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data       (data),
        .frame_type (frame_type),
        .position   (position),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (chk_errors),
        .pending    (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        int r;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 80;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (!rx_idle_en)
                out_ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    stall = (r >= 97) ? $urandom_range(10, 40) : $urandom_range(0, 3);
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        n_items++;
        if (tx_idle_en && $urandom_range(0, 99) < 25)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] sof, input int plen,
                              input logic [BYTE_W-1:0] ftype, input bit bad_sum);
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        len = BYTE_W'(plen + 2);
        sum = XOR_SEED ^ len ^ ftype;
        send_byte(sof);
        send_byte(len);
        send_byte(ftype);
        repeat (plen)
        begin
            b = BYTE_W'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        if (bad_sum)
            sum = sum ^ BYTE_W'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // drain all results, then give the output buffer time to empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [BYTE_W-1:0] sof, input logic [BYTE_W-1:0] mlen);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOF_BYTE;
        cfg_data  <= sof;
        @(posedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= mlen;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_sof = sof;
        cur_max = mlen;
    endtask

    task automatic random_phase(input int count);
        int target;
        int r;
        int maxp;
        int plen;
        logic [BYTE_W-1:0] len;
        target = n_items + count;
        while (n_items < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                if (cur_max < LEN_MIN)
                begin
                    send_byte(cur_sof);
                    send_byte(BYTE_W'($urandom));
                end
                else
                begin
                    maxp = int'(cur_max - LEN_MIN);
                    if ($urandom_range(0, 19) == 0)
                        plen = $urandom_range(0, maxp);
                    else
                        plen = $urandom_range(0, (maxp < 10) ? maxp : 10);
                    send_frame(cur_sof, plen, BYTE_W'($urandom_range(0, 1)),
                               $urandom_range(0, 9) == 0);
                end
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
            end
            else
            begin
                // broken header: length out of range or a bad type byte
                len = BYTE_W'($urandom);
                send_byte(cur_sof);
                send_byte(len);
                if (len >= LEN_MIN && len <= cur_max)
                    send_byte(BYTE_W'($urandom_range(2, 255)));
            end
        end
    endtask

    initial
    begin
        in_valid   = 1'b0;
        rx_byte    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SOF_BYTE;
        cfg_data   = '0;
        rst_n      = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_req   = 1'b0;
        n_items    = 0;
        cur_sof    = SOF_RESET;
        cur_max    = MAXLEN_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes outside a frame are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty payload
        send_frame(cur_sof, 0, 8'h00, 1'b0);
        // length too short
        send_byte(cur_sof);
        send_byte(8'h00);
        send_byte(cur_sof);
        send_byte(8'h01);
        // type above 1 returns to hunt
        send_byte(cur_sof);
        send_byte(8'h03);
        send_byte(8'h02);
        // start byte inside payload, bad checksum (good one is 0x04)
        send_byte(cur_sof);
        send_byte(8'h04);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h05);

        // long receiver hold while the sender streams a payload
        tx_idle_en = 1'b0;
        hold_req = 1'b1;
        send_frame(cur_sof, 30, 8'h01, 1'b0);
        tx_idle_en = 1'b1;
        // largest frame
        send_frame(cur_sof, 253, 8'h00, 1'b0);

        random_phase(300);
        for (int p = 0; p < 4; p++)
        begin
            settle();
            write_regs(phase_sof[p], phase_max[p]);
            tx_idle_en = (p != 1);
            rx_idle_en = (p != 1);
            random_phase(300);
        end
        settle();

        if (chk_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sfd_pkg.sv
hdl/sfd_parse.sv
hdl/sfd_out_buf.sv
hdl/serial_frame_deframer.sv
bench/sfd_checker.sv
bench/tb_serial_frame_deframer.sv
